// File: rtl/pmsl_pkg.sv
// Package: constants, codes and item types for the prefix match lookup
`default_nettype none
package pmsl_pkg;
    localparam int Entries  = 64;
    localparam int NameLen  = 32;
    localparam int EntW     = 6;
    localparam int PosW     = 5;
    localparam int CntW     = 31;
    localparam int TotW     = 7;
    localparam int NameAw   = EntW + PosW;
    localparam int QlenW    = PosW + 1;

    typedef enum logic [2:0] {
        FUNC_CLEAR  = 3'd0,
        FUNC_NAME   = 3'd1,
        FUNC_APPEND = 3'd2,
        FUNC_QUERY  = 3'd3,
        FUNC_RUN    = 3'd4
    } t_func;

    typedef struct packed {
        logic [2:0]      func;
        logic [5:0]      entry;
        logic [4:0]      position;
        logic [7:0]      byte_value;
        logic [30:0]     visitor_count;
        logic [5:0]      query_length;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [5:0]  match_index;
        logic [30:0] match_visitors;
        logic        last;
    } t_out_item;
endpackage
`default_nettype wire

// File: rtl/prefix_match_sorted_lookup.sv
// Top level: table of named entries, prefix search, count-ordered results
//
//  channel | ports                      | handshake
//  in      | i_item                     | start & !busy
//  out     | o_result                   | o_result_valid, one cycle, no stall
//
// A run takes: a query scan (query bytes examined up to a zero byte, the
// query length or NameLen), a match pass (each entry's name bytes compared
// with the query), an insertion sort over the match list memory, then one
// result per match, or a single not-found result.
// All steps go through one-read-port memories; busy is high for the whole run.
// Results cannot be stalled. Reset is synchronous active low; no clearing pass.
`default_nettype none
module prefix_match_sorted_lookup (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    input  pmsl_pkg::t_in_item    i_item,
    output logic                  busy,
    output logic                  o_result_valid,
    output pmsl_pkg::t_out_item   o_result
);
    typedef enum logic [4:0] {
        S_IDLE, S_QRD, S_QCHK, S_ENT, S_NRD, S_NCHK, S_SINIT, S_KRD, S_KCRD,
        S_KCAP, S_PRD, S_PCRD, S_PCMP, S_PLACE, S_ORD, S_OCRD, S_OEMIT, S_NONE
    } t_state;

    logic [7:0] name_mem [2**pmsl_pkg::NameAw];
    logic [pmsl_pkg::CntW-1:0] cnt_mem [pmsl_pkg::Entries];
    logic [7:0] qry_mem [pmsl_pkg::NameLen];
    logic [pmsl_pkg::EntW-1:0] ml_mem [pmsl_pkg::Entries];

    t_state r_state;
    logic [pmsl_pkg::TotW-1:0] r_total, r_n, r_i, r_k;
    logic [pmsl_pkg::QlenW-1:0] r_qlen, r_qmax, r_pos;
    logic [pmsl_pkg::EntW-1:0] r_ent, r_key, r_prev;
    logic [pmsl_pkg::CntW-1:0] r_kc;
    logic [7:0] r_name_q, r_qry_q;
    logic [pmsl_pkg::CntW-1:0] r_cnt_q;
    logic [pmsl_pkg::EntW-1:0] r_ml_q;

    logic                            name_we, qry_we, cnt_we, ml_we;
    logic [pmsl_pkg::NameAw-1:0]     name_wa, name_ra;
    logic [pmsl_pkg::PosW-1:0]       qry_wa, qry_ra;
    logic [pmsl_pkg::EntW-1:0]       cnt_wa, cnt_ra, ml_wa, ml_ra, ml_wd;
    logic [7:0]                      name_wd, qry_wd;
    logic [pmsl_pkg::CntW-1:0]       cnt_wd;
    logic                            accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // load-side writes
    always_comb begin
        name_we = accept && i_item.func == pmsl_pkg::FUNC_NAME;
        name_wa = {i_item.entry, i_item.position};
        name_wd = i_item.byte_value;
        qry_we  = accept && i_item.func == pmsl_pkg::FUNC_QUERY;
        qry_wa  = i_item.position;
        qry_wd  = i_item.byte_value;
        cnt_we  = accept && i_item.func == pmsl_pkg::FUNC_APPEND
                  && r_total < pmsl_pkg::TotW'(pmsl_pkg::Entries);
        cnt_wa  = r_total[pmsl_pkg::EntW-1:0];
        cnt_wd  = i_item.visitor_count;
    end

    // read addresses per state, and match list writes
    always_comb begin
        name_ra = {r_ent, r_pos[pmsl_pkg::PosW-1:0]};
        qry_ra  = r_pos[pmsl_pkg::PosW-1:0];
        cnt_ra  = r_ml_q;
        ml_ra   = r_i[pmsl_pkg::EntW-1:0];
        ml_we   = 1'b0;
        ml_wa   = r_n[pmsl_pkg::EntW-1:0];
        ml_wd   = r_ent;
        case (r_state)
            S_KRD:   ml_ra = r_i[pmsl_pkg::EntW-1:0];
            S_PRD:   ml_ra = r_k[pmsl_pkg::EntW-1:0] - 1'b1;
            S_ORD:   ml_ra = r_i[pmsl_pkg::EntW-1:0];
            default: ml_ra = r_i[pmsl_pkg::EntW-1:0];
        endcase
        case (r_state)
            S_NCHK: begin
                ml_we = (r_pos == r_qlen);
            end
            S_PCMP: begin
                ml_we = (r_cnt_q < r_kc);
                ml_wa = r_k[pmsl_pkg::EntW-1:0];
                ml_wd = r_prev;
            end
            S_PLACE: begin
                ml_we = 1'b1;
                ml_wa = r_k[pmsl_pkg::EntW-1:0];
                ml_wd = r_key;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (name_we) name_mem[name_wa] <= name_wd;
        if (qry_we)  qry_mem[qry_wa]   <= qry_wd;
        if (cnt_we)  cnt_mem[cnt_wa]   <= cnt_wd;
        if (ml_we)   ml_mem[ml_wa]     <= ml_wd;
        r_name_q <= name_mem[name_ra];
        r_qry_q  <= qry_mem[qry_ra];
        r_cnt_q  <= cnt_mem[cnt_ra];
        r_ml_q   <= ml_mem[ml_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_total        <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_item.func)
                            pmsl_pkg::FUNC_CLEAR:  r_total <= '0;
                            pmsl_pkg::FUNC_APPEND: if (cnt_we) r_total <= r_total + 1'b1;
                            pmsl_pkg::FUNC_RUN: begin
                                r_qmax  <= i_item.query_length;
                                r_pos   <= '0;
                                r_qlen  <= '0;
                                r_state <= S_QRD;
                            end
                            default: ;
                        endcase
                    end
                end
                // query length scan
                S_QRD: begin
                    if (r_pos >= r_qmax
                        || r_pos == pmsl_pkg::QlenW'(pmsl_pkg::NameLen)) begin
                        r_qlen  <= r_pos;
                        r_n     <= '0;
                        r_ent   <= '0;
                        r_state <= (r_pos >= pmsl_pkg::QlenW'(pmsl_pkg::NameLen)
                                    || r_total == '0) ? S_SINIT : S_ENT;
                    end else begin
                        r_state <= S_QCHK;
                    end
                end
                S_QCHK: begin
                    if (r_qry_q == 8'd0) begin
                        r_qlen  <= r_pos;
                        r_n     <= '0;
                        r_ent   <= '0;
                        r_state <= (r_total == '0) ? S_SINIT : S_ENT;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_QRD;
                    end
                end
                // match pass
                S_ENT: begin
                    r_pos   <= '0;
                    r_state <= S_NRD;
                end
                S_NRD: r_state <= S_NCHK;
                S_NCHK: begin
                    if (r_pos != r_qlen && r_name_q == r_qry_q) begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_NRD;
                    end else begin
                        if (r_pos == r_qlen) r_n <= r_n + 1'b1;
                        if ({1'b0, r_ent} == r_total - 1'b1) begin
                            r_state <= S_SINIT;
                        end else begin
                            r_ent   <= r_ent + 1'b1;
                            r_state <= S_ENT;
                        end
                    end
                end
                // insertion sort
                S_SINIT: begin
                    r_i <= pmsl_pkg::TotW'(1);
                    if (r_n == '0) r_state <= S_NONE;
                    else r_state <= S_KRD;
                end
                S_KRD: begin
                    if (r_i >= r_n) begin
                        r_i     <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_state <= S_KCRD;
                    end
                end
                S_KCRD: begin
                    r_key   <= r_ml_q;
                    r_state <= S_KCAP;
                end
                S_KCAP: begin
                    r_kc    <= r_cnt_q;
                    r_k     <= r_i;
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    if (r_k == '0) r_state <= S_PLACE;
                    else r_state <= S_PCRD;
                end
                S_PCRD: begin
                    r_prev  <= r_ml_q;
                    r_state <= S_PCMP;
                end
                S_PCMP: begin
                    if (r_cnt_q < r_kc) begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_PRD;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_KRD;
                end
                // output
                S_ORD: r_state <= S_OCRD;
                S_OCRD: r_state <= S_OEMIT;
                S_OEMIT: begin
                    o_result_valid          <= 1'b1;
                    o_result.found          <= 1'b1;
                    o_result.match_index    <= r_ml_q;
                    o_result.match_visitors <= r_cnt_q;
                    o_result.last           <= (r_i + 1'b1 == r_n);
                    if (r_i + 1'b1 == r_n) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ORD;
                    end
                end
                S_NONE: begin
                    o_result_valid <= 1'b1;
                    o_result       <= '{found: 1'b0, match_index: '0,
                                        match_visitors: '0, last: 1'b1};
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !accept) else $error("item accepted while busy");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= pmsl_pkg::TotW'(pmsl_pkg::Entries)) else $error("total overflow");
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.last |-> busy) else $error("run ended early");
`endif
endmodule
`default_nettype wire
